[rtl/core/strongly_connected_components_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the strongly connected components block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef STRONGLY_CONNECTED_COMPONENTS_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENTS_ASSERT_SVH

// same-cycle implication
`define SCC_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scc assertion failed");

// next-cycle implication
`define SCC_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scc assertion failed");

`endif

[rtl/core/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Constants, command codes and status bundle shared by the SCC block.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = 10;  // node index
  localparam int CNT_W     = 11;  // 0..MAX_NODES
  localparam int EIDX_W    = 12;  // edge index
  localparam int OFFS_W    = 13;  // offset word, 0..8191
  localparam int VIS_W     = NODE_W + 2;          // {visited, on_stack, disc}
  localparam int FRAME_W   = NODE_W + OFFS_W;     // {node, cursor}

  localparam logic [2:0] F_LOAD_OFFS = 3'd0;
  localparam logic [2:0] F_LOAD_EDGE = 3'd1;
  localparam logic [2:0] F_RUN       = 3'd2;
  localparam logic [2:0] F_READ_COMP = 3'd3;
  localparam logic [2:0] F_READ_HIST = 3'd4;

  typedef enum logic [4:0] {
    OP_IDLE, OP_ACCEPT, OP_RDRES, OP_CLR, OP_ROOT, OP_ROOTCHK,
    OP_E0, OP_E1, OP_E2, OP_LOOP, OP_EDGE1, OP_EDGE2, OP_FIN,
    OP_POP0, OP_POP1, OP_HIST0, OP_HIST1, OP_RET, OP_RET1, OP_RET2, OP_DONE
  } op_t;

  typedef struct packed {
    logic addr_ok;
    logic out_full;
    logic clr_done;
    logic r_done;
    logic visited;
    logic cur_lt_end;
    logic w_ignore;
    logic low_eq_disc;
    logic pop_more;
    logic fd_zero;
  } stat_t;

endpackage

[rtl/core/scc_ram.sv]
// ----------------------------------------------------------------------------
// scc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/scc_ctrl.sv]
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: walks the load/read handshake and the Tarjan search steps.
// ----------------------------------------------------------------------------
module scc_ctrl
  import scc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] func,
  input  stat_t      st,
  output logic       in_stall,
  output op_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_RDRES, S_CLR, S_ROOT, S_ROOTCHK, S_E0, S_E1, S_E2, S_LOOP,
    S_EDGE1, S_EDGE2, S_FIN, S_POP0, S_POP1, S_HIST0, S_HIST1,
    S_RET, S_RET1, S_RET2, S_DONE
  } state_t;

  state_t state;
  logic   take;

  assign in_stall = !(state == S_IDLE && !st.out_full);
  assign take     = in_valid && !in_stall;

  always_comb begin
    unique case (state)
      S_IDLE:    cmd = take ? OP_ACCEPT : OP_IDLE;
      S_RDRES:   cmd = OP_RDRES;
      S_CLR:     cmd = OP_CLR;
      S_ROOT:    cmd = OP_ROOT;
      S_ROOTCHK: cmd = OP_ROOTCHK;
      S_E0:      cmd = OP_E0;
      S_E1:      cmd = OP_E1;
      S_E2:      cmd = OP_E2;
      S_LOOP:    cmd = OP_LOOP;
      S_EDGE1:   cmd = OP_EDGE1;
      S_EDGE2:   cmd = OP_EDGE2;
      S_FIN:     cmd = OP_FIN;
      S_POP0:    cmd = OP_POP0;
      S_POP1:    cmd = OP_POP1;
      S_HIST0:   cmd = OP_HIST0;
      S_HIST1:   cmd = OP_HIST1;
      S_RET:     cmd = OP_RET;
      S_RET1:    cmd = OP_RET1;
      S_RET2:    cmd = OP_RET2;
      S_DONE:    cmd = OP_DONE;
      default:   cmd = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (func == F_RUN) begin
              state <= S_CLR;
            end else if ((func == F_READ_COMP || func == F_READ_HIST) && st.addr_ok) begin
              state <= S_RDRES;
            end
          end
        end
        S_RDRES:   state <= S_IDLE;
        S_CLR:     if (st.clr_done) state <= S_ROOT;
        S_ROOT:    state <= st.r_done ? S_DONE : S_ROOTCHK;
        S_ROOTCHK: state <= st.visited ? S_ROOT : S_E0;
        S_E0:      state <= S_E1;
        S_E1:      state <= S_E2;
        S_E2:      state <= S_LOOP;
        S_LOOP:    state <= st.cur_lt_end ? S_EDGE1 : S_FIN;
        S_EDGE1:   state <= st.w_ignore ? S_LOOP : S_EDGE2;
        S_EDGE2:   state <= st.visited ? S_LOOP : S_E0;
        S_FIN:     state <= st.low_eq_disc ? S_POP0 : S_RET;
        S_POP0:    state <= S_POP1;
        S_POP1:    state <= st.pop_more ? S_POP0 : S_HIST0;
        S_HIST0:   state <= S_HIST1;
        S_HIST1:   state <= S_RET;
        S_RET:     state <= st.fd_zero ? S_ROOT : S_RET1;
        S_RET1:    state <= S_RET2;
        S_RET2:    state <= S_LOOP;
        S_DONE:    state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/scc_dp.sv]
// ----------------------------------------------------------------------------
// scc_dp
// Datapath: graph and search memories, cursors, counters, result register.
// ----------------------------------------------------------------------------
module scc_dp
  import scc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  op_t               cmd,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic [2:0]        func,
  input  logic [EIDX_W-1:0] addr,
  input  logic [OFFS_W-1:0] value,
  input  logic              out_stall,
  output stat_t             st,
  output logic              out_valid,
  output logic [CNT_W-1:0]  reply,
  output logic              status
);

  localparam logic [OFFS_W-1:0] EDGE_LIM = OFFS_W'(MAX_EDGES);

  // control registers
  logic [CNT_W-1:0]  n;
  logic              hist_ok;
  logic              active;
  // search registers
  logic [CNT_W-1:0]  clr_i, r, ns, next_disc, next_comp, size;
  logic [NODE_W-1:0] fd;
  logic [NODE_W-1:0] x, u, lowu, discu, clow;
  logic [OFFS_W-1:0] cur, endp;
  logic              sel_hist;

  // memory ports
  logic                offs_we, offs_re;
  logic [CNT_W-1:0]    offs_wa, offs_ra;
  logic [OFFS_W-1:0]   offs_rd;
  logic                edge_we, edge_re;
  logic [EIDX_W-1:0]   edge_ra;
  logic [OFFS_W-1:0]   edge_rd;
  logic                vis_we, vis_re;
  logic [NODE_W-1:0]   vis_wa, vis_ra;
  logic [VIS_W-1:0]    vis_wd, vis_rd;
  logic                low_we, low_re;
  logic [NODE_W-1:0]   low_wa, low_wd, low_rd;
  logic                comp_we, comp_re;
  logic [NODE_W-1:0]   comp_rd;
  logic                nstk_we, nstk_re;
  logic [NODE_W-1:0]   nstk_rd;
  logic                fr_we, fr_re;
  logic [FRAME_W-1:0]  fr_rd;
  logic                hist_we, hist_re;
  logic [CNT_W-1:0]    hist_wa, hist_ra, hist_wd, hist_rd;

  logic [NODE_W-1:0]   p_node;
  logic [OFFS_W-1:0]   offs_clamp;
  logic                w_lower, clow_less;

  assign p_node     = fr_rd[FRAME_W-1 -: NODE_W];
  assign offs_clamp = (offs_rd > EDGE_LIM) ? EDGE_LIM : offs_rd;
  assign w_lower    = vis_rd[NODE_W] && (vis_rd[NODE_W-1:0] < lowu);
  assign clow_less  = clow < low_rd;

  // status toward the sequencer
  always_comb begin
    unique case (func)
      F_LOAD_OFFS, F_READ_HIST: st.addr_ok = addr <= {1'b0, n};
      F_LOAD_EDGE:              st.addr_ok = 1'b1;
      F_READ_COMP:              st.addr_ok = addr < {1'b0, n};
      default:                  st.addr_ok = 1'b0;
    endcase
    st.out_full    = out_valid;
    st.clr_done    = clr_i == CNT_W'(MAX_NODES);
    st.r_done      = r == n;
    st.visited     = vis_rd[VIS_W-1];
    st.cur_lt_end  = cur < endp;
    st.w_ignore    = edge_rd >= {2'b00, n};
    st.low_eq_disc = lowu == discu;
    st.pop_more    = (nstk_rd != u) && (ns != '0);
    st.fd_zero     = fd == '0;
  end

  // memory port steering
  always_comb begin
    offs_we = (cmd == OP_ACCEPT) && (func == F_LOAD_OFFS) && st.addr_ok;
    offs_wa = addr[CNT_W-1:0];
    offs_re = (cmd == OP_E0) || (cmd == OP_E1) || (cmd == OP_RET1);
    unique case (cmd)
      OP_E0:   offs_ra = {1'b0, x};
      OP_E1:   offs_ra = {1'b0, x} + 1'b1;
      default: offs_ra = {1'b0, p_node} + 1'b1;
    endcase

    edge_we = (cmd == OP_ACCEPT) && (func == F_LOAD_EDGE);
    edge_re = cmd == OP_LOOP;
    edge_ra = cur[EIDX_W-1:0];

    vis_we = ((cmd == OP_CLR) && !clr_i[CNT_W-1]) || (cmd == OP_E0) || (cmd == OP_POP1);
    unique case (cmd)
      OP_CLR:  begin vis_wa = clr_i[NODE_W-1:0]; vis_wd = '0; end
      OP_E0:   begin vis_wa = x; vis_wd = {2'b11, next_disc[NODE_W-1:0]}; end
      default: begin vis_wa = nstk_rd; vis_wd = {2'b10, {NODE_W{1'b0}}}; end
    endcase
    vis_re = (cmd == OP_ROOT) || (cmd == OP_EDGE1) || (cmd == OP_RET1);
    unique case (cmd)
      OP_ROOT:  vis_ra = r[NODE_W-1:0];
      OP_EDGE1: vis_ra = edge_rd[NODE_W-1:0];
      default:  vis_ra = p_node;
    endcase

    low_we = (cmd == OP_E0) || ((cmd == OP_EDGE2) && st.visited && w_lower) ||
             ((cmd == OP_RET2) && clow_less);
    unique case (cmd)
      OP_E0:    begin low_wa = x; low_wd = next_disc[NODE_W-1:0]; end
      OP_EDGE2: begin low_wa = u; low_wd = vis_rd[NODE_W-1:0]; end
      default:  begin low_wa = u; low_wd = clow; end
    endcase
    low_re = cmd == OP_RET1;

    comp_we = cmd == OP_POP1;
    comp_re = (cmd == OP_ACCEPT) && (func == F_READ_COMP);

    nstk_we = cmd == OP_E0;
    nstk_re = cmd == OP_POP0;

    fr_we = (cmd == OP_E0) && active;
    fr_re = (cmd == OP_RET) && !st.fd_zero;

    hist_we = (cmd == OP_CLR) || (cmd == OP_HIST1);
    hist_wa = (cmd == OP_CLR) ? clr_i : size;
    hist_wd = (cmd == OP_CLR) ? '0 : hist_rd + 1'b1;
    hist_re = (cmd == OP_HIST0) || ((cmd == OP_ACCEPT) && (func == F_READ_HIST));
    hist_ra = (cmd == OP_HIST0) ? size : addr[CNT_W-1:0];
  end

  scc_ram #(.WIDTH(OFFS_W), .DEPTH(MAX_NODES + 1)) u_offs (
    .clk, .we(offs_we), .waddr(offs_wa), .wdata(value),
    .re(offs_re), .raddr(offs_ra), .rdata(offs_rd)
  );
  scc_ram #(.WIDTH(OFFS_W), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(edge_we), .waddr(addr), .wdata(value),
    .re(edge_re), .raddr(edge_ra), .rdata(edge_rd)
  );
  scc_ram #(.WIDTH(VIS_W), .DEPTH(MAX_NODES)) u_vis (
    .clk, .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
    .re(vis_re), .raddr(vis_ra), .rdata(vis_rd)
  );
  scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_low (
    .clk, .we(low_we), .waddr(low_wa), .wdata(low_wd),
    .re(low_re), .raddr(p_node), .rdata(low_rd)
  );
  scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_comp (
    .clk, .we(comp_we), .waddr(nstk_rd), .wdata(next_comp[NODE_W-1:0]),
    .re(comp_re), .raddr(addr[NODE_W-1:0]), .rdata(comp_rd)
  );
  scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_nstk (
    .clk, .we(nstk_we), .waddr(ns[NODE_W-1:0]), .wdata(x),
    .re(nstk_re), .raddr(ns[NODE_W-1:0] - 1'b1), .rdata(nstk_rd)
  );
  scc_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_NODES)) u_frame (
    .clk, .we(fr_we), .waddr(fd), .wdata({u, cur}),
    .re(fr_re), .raddr(fd - 1'b1), .rdata(fr_rd)
  );
  scc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES + 1)) u_hist (
    .clk, .we(hist_we), .waddr(hist_wa), .wdata(hist_wd),
    .re(hist_re), .raddr(hist_ra), .rdata(hist_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= CNT_W'(1);
      hist_ok   <= 1'b0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_data == '0) begin
          n <= CNT_W'(1);
        end else if (cfg_data > CNT_W'(MAX_NODES)) begin
          n <= CNT_W'(MAX_NODES);
        end else begin
          n <= cfg_data;
        end
      end
      if ((cmd == OP_ACCEPT) && (func == F_RUN)) begin
        hist_ok <= 1'b1;
        active  <= 1'b0;
      end
      if (cmd == OP_E0) begin
        active <= 1'b1;
      end
      if ((cmd == OP_RET) && st.fd_zero) begin
        active <= 1'b0;
      end
      if (cmd == OP_RDRES || cmd == OP_DONE ||
          (cmd == OP_ACCEPT && func != F_RUN &&
           !((func == F_READ_COMP || func == F_READ_HIST) && st.addr_ok))) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      OP_ACCEPT: begin
        sel_hist  <= func == F_READ_HIST;
        reply     <= '0;
        status    <= !st.addr_ok;
        clr_i     <= '0;
        r         <= '0;
        ns        <= '0;
        fd        <= '0;
        next_disc <= '0;
        next_comp <= '0;
      end
      OP_RDRES: begin
        status <= 1'b0;
        if (sel_hist) begin
          reply <= hist_ok ? hist_rd : '0;
        end else begin
          reply <= {1'b0, comp_rd};
        end
      end
      OP_CLR: clr_i <= clr_i + 1'b1;
      OP_ROOTCHK: begin
        if (st.visited) begin
          r <= r + 1'b1;
        end else begin
          x <= r[NODE_W-1:0];
        end
      end
      OP_E0: begin
        u         <= x;
        discu     <= next_disc[NODE_W-1:0];
        lowu      <= next_disc[NODE_W-1:0];
        next_disc <= next_disc + 1'b1;
        ns        <= ns + 1'b1;
        if (active) begin
          fd <= fd + 1'b1;
        end
      end
      OP_E1: cur <= offs_rd;
      OP_E2: endp <= offs_clamp;
      OP_LOOP: if (st.cur_lt_end) cur <= cur + 1'b1;
      OP_EDGE1: x <= edge_rd[NODE_W-1:0];
      OP_EDGE2: if (st.visited && w_lower) lowu <= vis_rd[NODE_W-1:0];
      OP_FIN: size <= '0;
      OP_POP0: ns <= ns - 1'b1;
      OP_POP1: size <= size + 1'b1;
      OP_HIST1: next_comp <= next_comp + 1'b1;
      OP_RET: begin
        if (st.fd_zero) begin
          r <= r + 1'b1;
        end else begin
          fd <= fd - 1'b1;
        end
      end
      OP_RET1: begin
        clow <= lowu;
        u    <= p_node;
        cur  <= fr_rd[OFFS_W-1:0];
      end
      OP_RET2: begin
        discu <= vis_rd[NODE_W-1:0];
        endp  <= offs_clamp;
        lowu  <= clow_less ? clow : low_rd;
      end
      OP_DONE: begin
        reply  <= next_comp;
        status <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/strongly_connected_components.sv]
// Loads and bad requests give their beat in the cycle after acceptance, reads
//   after the read-result state; requests wait until the result register drains.
// A run first clears the visit marks and size histogram, one entry a cycle, then
//   scans the roots, enters and leaves each node, follows each edge, and pops
//   each component off the node stack and counts its size in the histogram.
// Reset: synchronous, active high; node count returns to 1, no result pending.
// ----------------------------------------------------------------------------
// strongly_connected_components
// Tarjan SCC engine over a graph loaded in CSR form, with component and
// size-histogram readback.
// ----------------------------------------------------------------------------
module strongly_connected_components
  import scc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // node count register
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        func,
  input  logic [EIDX_W-1:0] addr,
  input  logic [OFFS_W-1:0] value,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  reply,
  output logic              status
);

  // The sequencer owns the step order of the search; the datapath holds
  // the memories (offsets, edges, visit marks, low links, labels, node
  // stack, call frames, histogram) and the top frame in registers.
  op_t   cmd;
  stat_t st;

  scc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .func, .st, .in_stall, .cmd
  );

  scc_dp u_dp (
    .clk, .rst, .cmd, .cfg_we, .cfg_data, .func, .addr, .value,
    .out_stall, .st, .out_valid, .reply, .status
  );

endmodule

[rtl/core/scc_chk.sv]
// ----------------------------------------------------------------------------
// scc_chk
// Port-level checks for the SCC block, bound to the top level.
// ----------------------------------------------------------------------------
`include "strongly_connected_components_assert.svh"

module scc_chk
  import scc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [2:0]        func,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CNT_W-1:0]  reply,
  input logic              status
);

  // a pending beat holds until taken
  `SCC_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // no new request while a beat is pending
  `SCC_IMPLIES(a_busy_out, out_valid, in_stall)
  // errored beats carry zero
  `SCC_IMPLIES(a_err_zero, out_valid && status, reply == '0)
  // loads answer in the next cycle
  `SCC_NEXT(a_load_fast, in_valid && !in_stall && (func == F_LOAD_OFFS || func == F_LOAD_EDGE),
            out_valid)

endmodule

bind strongly_connected_components scc_chk u_scc_chk (
  .clk, .rst, .in_valid, .in_stall, .func, .out_valid, .out_stall, .reply, .status
);
